// ===== hdl/sobel_pkg.sv =====
package sobel_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WD_W = COL_W + 1;
	localparam int ROW_W = 17;
	localparam int IMG_W_W = 11;
	localparam int IMG_H_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int SUM_W = 21;
	localparam int SQRT_STEPS = 11;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ACT_PIXEL = 1'b0,
		ACT_FLUSH = 1'b1
	} action_t;

	typedef struct packed {
		logic       action;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       frame_end;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic capture;
	} dp_cmd_t;

	typedef struct packed {
		logic have;
		logic sqrt_last;
	} dp_status_t;

endpackage

// ===== hdl/sobel_ctrl.sv =====
module sobel_ctrl import sobel_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SQRT = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   take;

	// output register parts result from the next item
	assign in_ready  = (state_q == ST_IDLE);
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load      = take;
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.capture   = (state_q == ST_HOLD) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take && status.have) state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (status.sqrt_last) state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (cmd.capture) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/sobel_dp.sv =====
module sobel_dp import sobel_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_item_t              in_item,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	output out_item_t             out_item
);

	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [23:0]        win_q [9];
	logic [23:0]        mem_a [MAX_WIDTH];
	logic [23:0]        mem_b [MAX_WIDTH];
	logic [23:0]        old_q, older_q;
	logic [WD_W-1:0]    wd;
	logic [IMG_H_W-1:0] ht;
	logic [23:0]        pix;
	logic [23:0]        old_v, older_v;
	logic               have;
	logic [COL_W-1:0]   cx;
	logic [ROW_W-1:0]   cy;
	logic [8:0]         mask;
	logic               done;
	logic [COL_W-1:0]   col_nx;
	logic [COL_W-1:0]   rd_addr;
	logic [SUM_W-1:0]   sum [3];
	logic [SUM_W-1:0]   v_q [3];
	logic [SUM_W-1:0]   r_q [3];
	logic [SUM_W-1:0]   bit_q;
	logic [3:0]         step_q;
	logic               done_q;
	out_item_t          out_q;

	always_comb begin
		if (width_q == '0) wd = WD_W'(1);
		else if (width_q > IMG_W_W'(MAX_WIDTH)) wd = WD_W'(MAX_WIDTH);
		else wd = WD_W'(width_q);
		ht = (height_q == '0) ? IMG_H_W'(1) : height_q;
		pix = (in_item.action == ACT_FLUSH) ? 24'd0
			: {in_item.in_blue, in_item.in_green, in_item.in_red};
		old_v   = old_q;
		older_v = older_q;
		have = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
		if (col_q != '0) begin
			cy = row_q - ROW_W'(1);
			cx = col_q - COL_W'(1);
		end else begin
			cy = row_q - ROW_W'(2);
			cx = COL_W'(wd - WD_W'(1));
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mask[r*3+c] = !((r == 0 && cy == '0)
					|| (r == 2 && cy >= ROW_W'(ht) - ROW_W'(1))
					|| (c == 0 && cx == '0)
					|| (c == 2 && WD_W'(cx) >= wd - WD_W'(1)));
			end
		end
		done = (cy >= ROW_W'(ht) - ROW_W'(1)) && (WD_W'(cx) >= wd - WD_W'(1));
		if (have && done) col_nx = '0;
		else if (WD_W'(col_q) + WD_W'(1) >= wd) col_nx = '0;
		else col_nx = col_q + COL_W'(1);
		rd_addr = cmd.load ? col_nx : col_q;
	end

	// gradient sum of squares per channel using the shifted window
	always_comb begin
		logic [23:0] w [9];
		logic signed [11:0] p [9];
		logic signed [11:0] gx, gy;
		for (int i = 0; i < 9; i++) w[i] = '0;
		for (int r = 0; r < 3; r++) begin
			w[r*3]   = win_q[r*3+1];
			w[r*3+1] = win_q[r*3+2];
		end
		w[2] = older_v;
		w[5] = old_v;
		w[8] = pix;
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 9; i++)
				p[i] = mask[i] ? $signed({4'd0, w[i][8*ch +: 8]}) : 12'sd0;
			gx = p[2] - p[0] + 12'sd2 * (p[5] - p[3]) + p[8] - p[6];
			gy = p[6] - p[0] + 12'sd2 * (p[7] - p[1]) + p[8] - p[2];
			sum[ch] = SUM_W'(gx * gx) + SUM_W'(gy * gy);
		end
	end

	assign status.have      = have;
	assign status.sqrt_last = (step_q == 4'(SQRT_STEPS - 1));
	assign out_item         = out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_b[col_q] <= old_v;
			mem_a[col_q] <= pix;
		end
		// registered read of the column the next beat uses, same column forwards the write
		if (cmd.load && rd_addr == col_q) begin
			old_q   <= pix;
			older_q <= old_v;
		end else begin
			old_q   <= mem_a[rd_addr];
			older_q <= mem_b[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMG_W_W'(640);
			height_q <= IMG_H_W'(480);
			col_q    <= '0;
			row_q    <= '0;
			step_q   <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_q <= cfg_data[IMG_W_W-1:0];
					REG_IMAGE_HEIGHT: height_q <= cfg_data[IMG_H_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= older_v;
				win_q[5] <= old_v;
				win_q[8] <= pix;
				col_q <= col_nx;
				if (have && done) begin
					row_q <= '0;
				end else if (WD_W'(col_q) + WD_W'(1) >= wd) begin
					if (row_q != '1) row_q <= row_q + ROW_W'(1);
				end
			end
			if (cmd.load) step_q <= '0;
			else if (cmd.sqrt_step) step_q <= step_q + 4'd1;
		end
	end

	// restoring square root, one result bit a cycle for all three channels
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int ch = 0; ch < 3; ch++) begin
				v_q[ch] <= sum[ch];
				r_q[ch] <= '0;
			end
			bit_q  <= SUM_W'(1) << (2 * (SQRT_STEPS - 1));
			done_q <= have && done;
		end else if (cmd.sqrt_step) begin
			for (int ch = 0; ch < 3; ch++) begin
				if (v_q[ch] >= r_q[ch] + bit_q) begin
					v_q[ch] <= v_q[ch] - (r_q[ch] + bit_q);
					r_q[ch] <= (r_q[ch] >> 1) + bit_q;
				end else begin
					r_q[ch] <= r_q[ch] >> 1;
				end
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.capture) begin
			logic [SUM_W-1:0] m [3];
			for (int ch = 0; ch < 3; ch++) begin
				m[ch] = (v_q[ch] > r_q[ch]) ? r_q[ch] + SUM_W'(1) : r_q[ch];
				if (m[ch] > SUM_W'(255)) m[ch] = SUM_W'(255);
			end
			out_q.out_red   <= m[0][7:0];
			out_q.out_green <= m[1][7:0];
			out_q.out_blue  <= m[2][7:0];
			out_q.frame_end <= done_q;
		end
	end

endmodule

// ===== hdl/sobel_edge_rgb.sv =====
// a beat that yields a result passes through the square-root and hold states to the output
// register, and no new beat is taken until that result is captured (11-step square root
// shared by the three channels); items that yield none are taken one per cycle
// the result lags its center pixel by one row plus one pixel of input beats
// reset: asynchronous, active low; counters and window cleared, registers
// back to 640 x 480, line store contents left as they are
module sobel_edge_rgb import sobel_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	sobel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	sobel_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_item  (out_data)
	);

endmodule

// ===== bench/sobel_edge_rgb_test.sv =====
`timescale 1ns / 100ps

module sobel_edge_rgb_test;
	import sobel_pkg::*;

	class edge_scoreboard;
		int unsigned img_w, img_h;
		logic [23:0] line_mem [0:2*MAX_WIDTH-1];
		logic [23:0] win [0:8];
		int unsigned col_pos, row_pos;
		out_item_t pending [$];
		int mismatches;

		function void clear();
			img_w = 640;
			img_h = 480;
			foreach (line_mem[i]) line_mem[i] = '0;
			foreach (win[i]) win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			pending.delete();
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_IMAGE_WIDTH) img_w = val[IMG_W_W-1:0];
			else img_h = val;
		endfunction

		function logic [7:0] magnitude(logic [23:0] m [0:8], int ch);
			int gx, gy, p, r;
			int unsigned s;
			gx = 0;
			gy = 0;
			for (int i = 0; i < 9; i++) begin
				p = (m[i] >> (8 * ch)) & 8'hff;
				case (i % 3)
					0: gx -= (i == 3 ? 2 : 1) * p;
					2: gx += (i == 5 ? 2 : 1) * p;
					default: ;
				endcase
				if (i < 3) gy -= (i == 1 ? 2 : 1) * p;
				else if (i >= 6) gy += (i == 7 ? 2 : 1) * p;
			end
			s = gx * gx + gy * gy;
			r = 0;
			while ((r + 1) * (r + 1) <= s) r++;
			// round to nearest: up when remainder exceeds r
			if (s - r * r > r) r++;
			return (r > 255) ? 8'hff : r[7:0];
		endfunction

		function void note_beat(in_item_t it);
			int unsigned wd, ht, col, cy, cx;
			logic [23:0] pix, older, old;
			logic [23:0] m [0:8];
			logic have, done, off;
			out_item_t res;
			wd = (img_w == 0) ? 1 : img_w;
			if (wd > MAX_WIDTH) wd = MAX_WIDTH;
			ht = (img_h == 0) ? 1 : img_h;
			col = (col_pos < MAX_WIDTH) ? col_pos : MAX_WIDTH - 1;
			pix = (it.action == ACT_PIXEL) ?
				{it.in_blue, it.in_green, it.in_red} : 24'h0;
			older = line_mem[MAX_WIDTH + col];
			old = line_mem[col];
			line_mem[MAX_WIDTH + col] = old;
			line_mem[col] = pix;
			for (int r = 0; r < 3; r++) begin
				win[r*3] = win[r*3+1];
				win[r*3+1] = win[r*3+2];
			end
			win[2] = older;
			win[5] = old;
			win[8] = pix;
			have = row_pos >= 2 || (row_pos == 1 && col_pos >= 1);
			done = 0;
			if (have) begin
				if (col_pos >= 1) begin
					cy = row_pos - 1;
					cx = col_pos - 1;
				end else begin
					cy = row_pos - 2;
					cx = wd - 1;
				end
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++) begin
						off = (r == 0 && cy == 0) || (r == 2 && cy >= ht - 1) ||
							(c == 0 && cx == 0) || (c == 2 && cx >= wd - 1);
						m[r*3+c] = off ? 24'h0 : win[r*3+c];
					end
				done = cy >= ht - 1 && cx >= wd - 1;
				res.out_red = magnitude(m, 0);
				res.out_green = magnitude(m, 1);
				res.out_blue = magnitude(m, 2);
				res.frame_end = done;
				pending.push_back(res);
			end
			if (done) begin
				col_pos = 0;
				row_pos = 0;
			end else begin
				col_pos++;
				if (col_pos >= wd) begin
					col_pos = 0;
					if (row_pos < 17'h1ffff) row_pos++;
				end
			end
		endfunction

		function void check_beat(out_item_t got);
			out_item_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			exp = pending.pop_front();
			if (got.out_red !== exp.out_red || got.out_green !== exp.out_green ||
				got.out_blue !== exp.out_blue || got.frame_end !== exp.frame_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected r%0d g%0d b%0d e%0d, got r%0d g%0d b%0d e%0d",
						exp.out_red, exp.out_green, exp.out_blue, exp.frame_end,
						got.out_red, got.out_green, got.out_blue, got.frame_end);
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic cfg_index = 0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_data;

	edge_scoreboard board;
	bit idle_on = 1;
	bit hold_off = 0;
	int quiet_cycles = 0;
	int frame_w, frame_h;

	sobel_edge_rgb u_top (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) board.note_beat(in_data);
			if (out_valid && out_ready) board.check_beat(out_data);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
		end
	end

	always @(posedge clk) begin
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 8);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, int val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		board.set_reg(idx, CFG_DATA_W'(val));
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_beat(action_t act, logic [23:0] rgb);
		int n;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 8);
			repeat (n) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= {act, rgb[23:16], rgb[15:8], rgb[7:0]};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// one frame: pixels, then width+1 flush beats; mode picks pixel content
	task automatic send_frame(int w, int h, int mode);
		logic [23:0] px;
		for (int i = 0; i < w * h; i++) begin
			case (mode)
				0: px = 24'($urandom);
				1: px = ((i / w + i % w) & 1) ? 24'hffffff : 24'h0;
				default: px = ($urandom_range(0, 1)) ? 24'hffffff : 24'h0;
			endcase
			send_beat(ACT_PIXEL, px);
		end
		for (int i = 0; i <= w; i++) send_beat(ACT_FLUSH, 24'($urandom));
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (12) @(negedge clk);
		arst_n = 1;

		// zero sizes act as one
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 0);
		send_frame(1, 1, 0);
		send_beat(ACT_PIXEL, 24'hffffff);
		send_beat(ACT_FLUSH, 24'h0);
		drain();
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 3);
		send_frame(3, 3, 1);
		// flush inside the frame counts as zero pixel
		send_beat(ACT_FLUSH, 24'h0);
		send_beat(ACT_PIXEL, 24'hffffff);
		for (int i = 0; i < 9; i++) send_beat(ACT_FLUSH, 24'h0);
		drain();

		// long receiver hold-off while input keeps coming
		write_reg(REG_IMAGE_WIDTH, 4);
		write_reg(REG_IMAGE_HEIGHT, 6);
		hold_off = 1;
		fork
			send_frame(4, 6, 0);
			begin
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
		join
		drain();

		// width beyond limit saturates, single row, mostly zeros plus one fixed pixel
		write_reg(REG_IMAGE_WIDTH, 2047);
		write_reg(REG_IMAGE_HEIGHT, 1);
		for (int i = 0; i < 100; i++) send_beat(ACT_FLUSH, 24'h0);
		send_beat(ACT_PIXEL, 24'h123456);
		for (int i = 0; i < 100; i++) send_beat(ACT_FLUSH, 24'h0);
		drain();

		for (int f = 0; f < 24; f++) begin
			frame_w = $urandom_range(1, 8);
			frame_h = $urandom_range(1, 4);
			if (f == 23) idle_on = 0;
			write_reg(REG_IMAGE_WIDTH, frame_w);
			write_reg(REG_IMAGE_HEIGHT, frame_h);
			send_frame(frame_w, frame_h, $urandom_range(0, 2));
			drain();
		end
		write_reg(REG_IMAGE_HEIGHT, 65535);
		for (int i = 0; i < 20; i++) send_beat(ACT_PIXEL, 24'($urandom));
		drain();

		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
